FILE: rtl/thick_line_quad_expand_core_macros.svh
// Assertion helpers shared by the front, queue and back RTL files.
`ifndef THICK_LINE_QUAD_EXPAND_CORE_MACROS_SVH
`define THICK_LINE_QUAD_EXPAND_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TLQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define TLQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/tlq_pkg.sv
`default_nettype none
package tlq_pkg;

    localparam int COORD_FRAC_BITS = 16;
    // offset product has 25 fractional bits after halving
    localparam int OFS_SHIFT = 25 - COORD_FRAC_BITS;
    localparam logic [32:0] OFS_ROUND = 33'(1) << (OFS_SHIFT - 1);

    localparam int SCALED_MSB = 23;
    localparam logic [4:0] SQRT_STEPS_M1 = 5'd24;
    localparam logic [4:0] DIV_STEPS_M1 = 5'd16;
    localparam logic [2:0] LAST_VERTEX_NUM = 3'd5;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [15:0]        width;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               degen;
        logic [23:0]        a;
        logic [23:0]        b;
        logic               neg_hx;
        logic               neg_hy;
    } seg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SUM,
        B_SQRT,
        B_DIVINIT,
        B_DIV,
        B_MUL,
        B_EMIT
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/tlq_front.sv
`default_nettype none
`include "thick_line_quad_expand_core_macros.svh"
module tlq_front
    import tlq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic [15:0]        line_width,
    input  wire logic [7:0]         color_red,
    input  wire logic [7:0]         color_green,
    input  wire logic [7:0]         color_blue,
    input  wire logic [7:0]         color_alpha,
    output logic                    push,
    output seg_t                    push_data,
    input  wire logic               q_ready
);

    logic               stage_valid_reg;
    logic signed [31:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [15:0]        width_reg;
    logic [7:0]         red_reg, green_reg, blue_reg, alpha_reg;

    logic signed [32:0] dx, dy;
    logic [32:0]        abs_a, abs_b, max_m, a_sh, b_sh;
    logic [5:0]         msb;

    assign push     = stage_valid_reg && q_ready;
    assign in_stall = stage_valid_reg && !q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sx_reg    <= start_x;
            sy_reg    <= start_y;
            ex_reg    <= end_x;
            ey_reg    <= end_y;
            width_reg <= line_width;
            red_reg   <= color_red;
            green_reg <= color_green;
            blue_reg  <= color_blue;
            alpha_reg <= color_alpha;
        end
    end

    always_comb
    begin
        dx    = 33'(ex_reg) - 33'(sx_reg);
        dy    = 33'(ey_reg) - 33'(sy_reg);
        abs_a = dx[32] ? 33'(-dx) : 33'(dx);
        abs_b = dy[32] ? 33'(-dy) : 33'(dy);
        max_m = (abs_a > abs_b) ? abs_a : abs_b;
        msb   = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (max_m[i])
            begin
                msb = 6'(i);
            end
        end
        // bring the larger magnitude into [2^23, 2^24)
        if (msb >= 6'(SCALED_MSB))
        begin
            a_sh = abs_a >> (msb - 6'(SCALED_MSB));
            b_sh = abs_b >> (msb - 6'(SCALED_MSB));
        end
        else
        begin
            a_sh = abs_a << (6'(SCALED_MSB) - msb);
            b_sh = abs_b << (6'(SCALED_MSB) - msb);
        end
        push_data.sx     = sx_reg;
        push_data.sy     = sy_reg;
        push_data.ex     = ex_reg;
        push_data.ey     = ey_reg;
        push_data.width  = width_reg;
        push_data.red    = red_reg;
        push_data.green  = green_reg;
        push_data.blue   = blue_reg;
        push_data.alpha  = alpha_reg;
        push_data.degen  = (dx == 33'sd0) && (dy == 33'sd0);
        push_data.a      = a_sh[23:0];
        push_data.b      = b_sh[23:0];
        push_data.neg_hx = !dy[32] && (dy != 33'sd0);
        push_data.neg_hy = dx[32];
    end

    `TLQ_ASSERT(a_held_when_stalled, in_stall |=> stage_valid_reg, "stage lost while stalled")
    `TLQ_NEVER(a_stall_no_stage, in_stall && !stage_valid_reg, "stall without held transaction")
    `TLQ_ASSERT(a_scaled_range, push && !push_data.degen |-> (push_data.a[23] || push_data.b[23]),
        "scaled magnitude out of range")

endmodule
`default_nettype wire

FILE: rtl/tlq_queue.sv
`default_nettype none
`include "thick_line_quad_expand_core_macros.svh"
module tlq_queue
    import tlq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire seg_t push_data,
    output logic      q_ready,
    output logic      q_valid,
    output seg_t      q_data,
    input  wire logic pop
);

    seg_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign q_ready = count_reg != 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TLQ_NEVER(a_push_full, push && !q_ready, "push into full queue")
    `TLQ_NEVER(a_pop_empty, pop && !q_valid, "pop from empty queue")
    `TLQ_NEVER(a_count_range, count_reg == 2'd3, "queue count overflow")

endmodule
`default_nettype wire

FILE: rtl/tlq_back.sv
`default_nettype none
`include "thick_line_quad_expand_core_macros.svh"
module tlq_back
    import tlq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire seg_t        q_data,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_alpha,
    output logic [2:0]       vertex_number,
    output logic             last_vertex,
    output logic             degenerate
);

    back_state_t        state_reg, state_next;
    seg_t               seg_reg;
    logic [47:0]        sqa_reg, sqb_reg;
    logic [49:0]        rad_reg;
    logic [25:0]        rem_reg;
    logic [24:0]        root_reg;
    logic [4:0]         cnt_reg;
    logic [41:0]        nda_reg, ndb_reg, den_reg;
    logic [16:0]        qa_reg, qb_reg;
    logic signed [32:0] hx_reg, hy_reg;
    logic [2:0]         vidx_reg;
    logic               out_valid_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic [2:0]         vnum_reg;
    logic               vlast_reg, vdegen_reg;
    logic [7:0]         r_reg, g_reg, bl_reg, al_reg;

    logic [27:0]        rem_ext, trial;
    logic               take;
    logic [32:0]        mag_x, mag_y;
    logic               use_end, plus;
    logic signed [33:0] sum_x, sum_y;
    logic signed [31:0] sat_x, sat_y;

    assign out_valid     = out_valid_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign out_red       = r_reg;
    assign out_green     = g_reg;
    assign out_blue      = bl_reg;
    assign out_alpha     = al_reg;
    assign vertex_number = vnum_reg;
    assign last_vertex   = vlast_reg;
    assign degenerate    = vdegen_reg;

    assign take = !out_valid_reg || !out_stall;

    always_comb
    begin
        rem_ext = {rem_reg, rad_reg[49:48]};
        trial   = {1'b0, root_reg, 2'b01};
        mag_x   = (33'(qb_reg) * 33'(seg_reg.width) + OFS_ROUND) >> OFS_SHIFT;
        mag_y   = (33'(qa_reg) * 33'(seg_reg.width) + OFS_ROUND) >> OFS_SHIFT;
        // vertex order: end+h, end-h, start-h, start-h, start+h, end+h
        use_end = (vidx_reg == 3'd0) || (vidx_reg == 3'd1) || (vidx_reg == 3'd5);
        plus    = (vidx_reg == 3'd0) || (vidx_reg == 3'd4) || (vidx_reg == 3'd5);
        sum_x   = 34'(use_end ? seg_reg.ex : seg_reg.sx) + (plus ? 34'(hx_reg) : -34'(hx_reg));
        sum_y   = 34'(use_end ? seg_reg.ey : seg_reg.sy) + (plus ? 34'(hy_reg) : -34'(hy_reg));
        if (sum_x > 34'sd2147483647)
            sat_x = 32'sh7fffffff;
        else if (sum_x < -34'sd2147483648)
            sat_x = 32'sh80000000;
        else
            sat_x = sum_x[31:0];
        if (sum_y > 34'sd2147483647)
            sat_y = 32'sh7fffffff;
        else if (sum_y < -34'sd2147483648)
            sat_y = 32'sh80000000;
        else
            sat_y = sum_y[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    state_next = q_data.degen ? B_EMIT : B_SQ;
                end
            end
            B_SQ:      state_next = B_SUM;
            B_SUM:     state_next = B_SQRT;
            B_SQRT:    state_next = (cnt_reg == 5'd0) ? B_DIVINIT : B_SQRT;
            B_DIVINIT: state_next = B_DIV;
            B_DIV:     state_next = (cnt_reg == 5'd0) ? B_MUL : B_DIV;
            B_MUL:     state_next = B_EMIT;
            B_EMIT:
            begin
                if (take && vidx_reg == LAST_VERTEX_NUM)
                begin
                    state_next = B_IDLE;
                end
            end
            default:   state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            vidx_reg      <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_EMIT && take)
            begin
                out_valid_reg <= 1'b1;
                vidx_reg      <= (vidx_reg == LAST_VERTEX_NUM) ? 3'd0 : vidx_reg + 3'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                seg_reg <= q_data;
                hx_reg  <= 33'sd0;
                hy_reg  <= 33'sd0;
            end
            B_SQ:
            begin
                sqa_reg <= 48'(seg_reg.a) * 48'(seg_reg.a);
                sqb_reg <= 48'(seg_reg.b) * 48'(seg_reg.b);
            end
            B_SUM:
            begin
                rad_reg  <= 50'(sqa_reg) + 50'(sqb_reg);
                rem_reg  <= 26'd0;
                root_reg <= 25'd0;
                cnt_reg  <= SQRT_STEPS_M1;
            end
            B_SQRT:
            begin
                // one result bit per cycle, two radicand bits consumed
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg - 5'd1;
                if (rem_ext >= trial)
                begin
                    rem_reg  <= 26'(rem_ext - trial);
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_ext[25:0];
                    root_reg <= {root_reg[23:0], 1'b0};
                end
            end
            B_DIVINIT:
            begin
                nda_reg <= {1'b0, seg_reg.a, 17'd0} + 42'(root_reg);
                ndb_reg <= {1'b0, seg_reg.b, 17'd0} + 42'(root_reg);
                den_reg <= {root_reg, 17'd0};
                cnt_reg <= DIV_STEPS_M1;
            end
            B_DIV:
            begin
                den_reg <= den_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
                if (nda_reg >= den_reg)
                begin
                    nda_reg <= nda_reg - den_reg;
                    qa_reg  <= {qa_reg[15:0], 1'b1};
                end
                else
                begin
                    qa_reg <= {qa_reg[15:0], 1'b0};
                end
                if (ndb_reg >= den_reg)
                begin
                    ndb_reg <= ndb_reg - den_reg;
                    qb_reg  <= {qb_reg[15:0], 1'b1};
                end
                else
                begin
                    qb_reg <= {qb_reg[15:0], 1'b0};
                end
            end
            B_MUL:
            begin
                hx_reg <= seg_reg.neg_hx ? -$signed(mag_x) : $signed(mag_x);
                hy_reg <= seg_reg.neg_hy ? -$signed(mag_y) : $signed(mag_y);
            end
            B_EMIT:
            begin
                if (take)
                begin
                    vx_reg     <= sat_x;
                    vy_reg     <= sat_y;
                    vnum_reg   <= vidx_reg;
                    vlast_reg  <= vidx_reg == LAST_VERTEX_NUM;
                    vdegen_reg <= seg_reg.degen;
                    r_reg      <= seg_reg.red;
                    g_reg      <= seg_reg.green;
                    bl_reg     <= seg_reg.blue;
                    al_reg     <= seg_reg.alpha;
                end
            end
            default:
            begin
            end
        endcase
    end

    `TLQ_NEVER(a_vnum_range, out_valid && vertex_number > LAST_VERTEX_NUM, "vertex number range")
    `TLQ_ASSERT(a_last_mark, out_valid |-> (last_vertex == (vertex_number == LAST_VERTEX_NUM)),
        "last mark mismatch")
    `TLQ_NEVER(a_pop_busy, pop && state_reg != B_IDLE, "pop while busy")
    `TLQ_ASSERT(a_idx_idle, state_reg == B_IDLE |-> vidx_reg == 3'd0, "vertex index not cleared")

endmodule
`default_nettype wire

FILE: rtl/thick_line_quad_expand_core.sv
// Thick line expander: one segment in, six vertices (two triangles) out.
// Input channel: in_valid/in_stall with start/end (signed fixed point),
//   line_width (unsigned Q8.8) and an RGBA colour. A transaction is taken on a
//   clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall, one vertex per transaction in the order
//   end+h, end-h, start-h, start-h, start+h, end+h, with vertex_number,
//   last_vertex on the sixth and degenerate when start equals end.
// For a normal segment the path runs through the input register, queue,
//   24x24 squares, bit-serial square root, restoring divide for both normal
//   components and offset multiply; a degenerate one goes from the queue
//   straight to vertex output.
// The sqrt and divide sequencer in the back end works on one segment at a
//   time and takes the next from the queue after its last vertex is taken.
// The front register and a two-entry queue keep taking segments while the
//   back end works, so the input only stalls once the queue is full.
// When the receiver holds out_stall the current vertex stays put and the
//   back end waits; nothing is dropped.
// Reset (rst_n low, async) empties the input stage, queue and output register.
`default_nettype none
module thick_line_quad_expand_core
    import tlq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic [15:0]        line_width,
    input  wire logic [7:0]         color_red,
    input  wire logic [7:0]         color_green,
    input  wire logic [7:0]         color_blue,
    input  wire logic [7:0]         color_alpha,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      vertex_x,
    output logic signed [31:0]      vertex_y,
    output logic [7:0]              out_red,
    output logic [7:0]              out_green,
    output logic [7:0]              out_blue,
    output logic [7:0]              out_alpha,
    output logic [2:0]              vertex_number,
    output logic                    last_vertex,
    output logic                    degenerate
);

    logic push, q_ready, q_valid, pop;
    seg_t push_data, q_data;

    tlq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_width  (line_width),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .color_alpha (color_alpha),
        .push        (push),
        .push_data   (push_data),
        .q_ready     (q_ready)
    );

    tlq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    tlq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_alpha     (out_alpha),
        .vertex_number (vertex_number),
        .last_vertex   (last_vertex),
        .degenerate    (degenerate)
    );

endmodule
`default_nettype wire

FILE: dv/tb_thick_line_quad_expand_core.sv
`default_nettype none
module tb_thick_line_quad_expand_core
    import tlq_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         a;
        logic [2:0]         num;
        logic               last;
        logic               degen;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic [15:0] line_width = '0;
    logic [7:0] color_red = '0, color_green = '0, color_blue = '0, color_alpha = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] vertex_x, vertex_y;
    logic [7:0] out_red, out_green, out_blue, out_alpha;
    logic [2:0] vertex_number;
    logic last_vertex, degenerate;

    vertex_t expected_vertices[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int in_idle_pct = 28;
    int out_idle_pct = 28;
    bit hold_output = 1'b0;
    bit stim_done = 1'b0;

    always #1 clk = ~clk;

    thick_line_quad_expand_core u_top (.*);

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint offset_mag(input logic [63:0] q, input bit neg,
                                          input logic [15:0] w);
        logic [63:0] m;
        m = (q * w + (64'd1 << (OFS_SHIFT - 1))) >> OFS_SHIFT;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // Expected six vertices for one segment
    task automatic predict_quad(input logic signed [31:0] sx, sy, ex, ey,
                                input logic [15:0] w, input logic [7:0] r, g, b, a);
        longint dx, dy, hx, hy;
        longint px[6], py[6];
        logic [63:0] ma, mb, mm, len, qa, qb;
        bit dg;
        vertex_t v;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        hx = 0;
        hy = 0;
        dg = (dx == 0 && dy == 0);
        if (!dg)
        begin
            ma = dx < 0 ? -dx : dx;
            mb = dy < 0 ? -dy : dy;
            mm = ma > mb ? ma : mb;
            while (mm >= (64'd1 << 24))
            begin
                ma = ma >> 1; mb = mb >> 1; mm = mm >> 1;
            end
            while (mm < (64'd1 << 23))
            begin
                ma = ma << 1; mb = mb << 1; mm = mm << 1;
            end
            len = int_sqrt(ma * ma + mb * mb);
            qa = (ma * 64'd131072 + len) / (2 * len);
            qb = (mb * 64'd131072 + len) / (2 * len);
            hx = offset_mag(qb, dy > 0, w);
            hy = offset_mag(qa, dx < 0, w);
        end
        px[0] = ex + hx; py[0] = ey + hy;
        px[1] = ex - hx; py[1] = ey - hy;
        px[2] = sx - hx; py[2] = sy - hy;
        px[3] = sx - hx; py[3] = sy - hy;
        px[4] = sx + hx; py[4] = sy + hy;
        px[5] = ex + hx; py[5] = ey + hy;
        for (int k = 0; k < 6; k++)
        begin
            v.x = clamp_coord(px[k]);
            v.y = clamp_coord(py[k]);
            v.r = r; v.g = g; v.b = b; v.a = a;
            v.num = 3'(k);
            v.last = (3'(k) == LAST_VERTEX_NUM);
            v.degen = dg;
            expected_vertices.insert(expected_vertices.size(), v);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, exp);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
    endtask

    task automatic send_segment(input logic signed [31:0] sx, sy, ex, ey,
                                input logic [15:0] w, input logic [7:0] r, g, b, a);
        while (($urandom_range(99) < in_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
        line_width <= w;
        color_red <= r; color_green <= g; color_blue <= b; color_alpha <= a;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_quad(sx, sy, ex, ey, w, r, g, b, a);
    endtask

    task automatic send_random(input int kind);
        logic signed [31:0] sx, sy, ex, ey;
        logic [15:0] w;
        sx = $urandom; sy = $urandom;
        w = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2048));
        case (kind)
            0:
            begin
                ex = sx; ey = sy;
            end
            1:
            begin
                ex = sx + $signed(32'($urandom_range(2000)) - 32'sd1000);
                ey = sy + $signed(32'($urandom_range(2000)) - 32'sd1000);
            end
            2:
            begin
                sx = $signed(32'h7fff0000) + $signed(32'($urandom_range(65535)));
                ex = sx - $signed(32'($urandom_range(1 << 20)));
                ey = sy + $signed(32'($urandom_range(1 << 16)));
            end
            default:
            begin
                ex = $urandom; ey = $urandom;
            end
        endcase
        send_segment(sx, sy, ex, ey, w, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic test_directed();
        send_segment(0, 0, 0, 0, 16'hffff, 8'h00, 8'hff, 8'h00, 8'hff);
        send_segment(32'sh10000, 32'sh20000, 32'sh10000, 32'sh20000, 0, 1, 2, 3, 4);
        send_segment(0, 0, 32'sh10000, 0, 16'h0100, 8'hff, 0, 8'hff, 0);
        send_segment(0, 0, 0, 32'sh10000, 16'h0200, 1, 1, 1, 1);
        send_segment(0, 0, -32'sh10000, 0, 16'h0300, 2, 2, 2, 2);
        send_segment(0, 0, 0, -32'sh10000, 16'hffff, 3, 3, 3, 3);
        send_segment(0, 0, 32'sh30000, 32'sh40000, 16'h0a00, 4, 4, 4, 4);
        send_segment(0, 0, 1, 1, 16'h0001, 5, 5, 5, 5);
        send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                     16'hffff, 6, 6, 6, 6);
        send_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                     16'hffff, 7, 7, 7, 7);
        send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7ffffff0,
                     16'hffff, 8, 8, 8, 8);
        send_segment(32'h80000000, 32'h80000000, 32'h80000010, 32'h80000000,
                     16'hffff, 9, 9, 9, 9);
        send_segment(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     16'h8000, 10, 10, 10, 10);
        send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     16'h8000, 11, 11, 11, 11);
        send_segment(0, 0, 3, -7, 16'h0001, 12, 12, 12, 12);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps pushing until the input stalls
    task automatic test_backpressure();
        hold_output = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_output = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_random(3);
        join
        wait_drained();
    endtask

    task automatic test_random();
        in_idle_pct = 0;
        out_idle_pct = 0;
        for (int i = 0; i < 40; i++) send_random($urandom_range(3));
        in_idle_pct = 28;
        out_idle_pct = 28;
        for (int i = 0; i < 400; i++) send_random($urandom_range(3));
        wait_drained();
    endtask

    always @(posedge clk)
        out_stall <= hold_output || ($urandom_range(99) < out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                report_mismatch("unexpected vertex_x", vertex_x, 32'd0);
            end
            else
            begin
                automatic vertex_t e = expected_vertices.pop_front();
                if (vertex_x !== e.x) report_mismatch("vertex_x", vertex_x, e.x);
                if (vertex_y !== e.y) report_mismatch("vertex_y", vertex_y, e.y);
                if (out_red !== e.r) report_mismatch("out_red", 32'(out_red), 32'(e.r));
                if (out_green !== e.g)
                    report_mismatch("out_green", 32'(out_green), 32'(e.g));
                if (out_blue !== e.b) report_mismatch("out_blue", 32'(out_blue), 32'(e.b));
                if (out_alpha !== e.a)
                    report_mismatch("out_alpha", 32'(out_alpha), 32'(e.a));
                if (vertex_number !== e.num)
                    report_mismatch("vertex_number", 32'(vertex_number), 32'(e.num));
                if (last_vertex !== e.last)
                    report_mismatch("last_vertex", 32'(last_vertex), 32'(e.last));
                if (degenerate !== e.degen)
                    report_mismatch("degenerate", 32'(degenerate), 32'(e.degen));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !stim_done)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        stim_done = 1'b1;
        if (mismatch_count == 0 && expected_vertices.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
